/* src/qtse_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtse_pkg: shared types and constants
// Word formats, shape codes and the front-to-back work word of the quadratic
// triangle shape evaluator.
// ----------------------------------------------------------------------------
package qtse_pkg;

  // fixed word formats
  localparam int COORD_W        = 32;   // vertex coordinates, Q16.16
  localparam int BARY_W         = 32;   // barycentric coordinates
  localparam int OUT_W          = 48;   // results, Q24.24
  localparam int BARY_FRAC_DEF  = 28;
  localparam int SLOPE_FRAC_REF = 40;   // slope numerator scale reference
  localparam int VALUE_FRAC     = 24;   // fraction bits of the results

  // derived operand widths
  localparam int DIFF_W = COORD_W + 1;        // coordinate difference
  localparam int OPA_W  = BARY_W + 3;         // 4*L - 1 term
  localparam int VALM_W = BARY_W + 2;         // 2*L - 1 term
  localparam int PROD_W = OPA_W + DIFF_W;     // slope partial product
  localparam int VAL_W  = BARY_W + VALM_W;    // value product
  localparam int JP_W   = 2 * DIFF_W;         // area partial product
  localparam int J2_W   = JP_W + 1;           // twice the signed area
  localparam int QUOT_W = OUT_W;              // quotient bits of the divider

  localparam int FIFO_DEPTH = 2;

  // shape function codes
  localparam logic [2:0] SHAPE_CORNER_A = 3'd0;
  localparam logic [2:0] SHAPE_CORNER_B = 3'd1;
  localparam logic [2:0] SHAPE_CORNER_C = 3'd2;
  localparam logic [2:0] SHAPE_EDGE_AB  = 3'd3;
  localparam logic [2:0] SHAPE_EDGE_BC  = 3'd4;
  localparam logic [2:0] SHAPE_EDGE_CA  = 3'd5;

  typedef struct packed {
    logic [2:0]                shape_index;
    logic signed [COORD_W-1:0] vertex_ax;
    logic signed [COORD_W-1:0] vertex_ay;
    logic signed [COORD_W-1:0] vertex_bx;
    logic signed [COORD_W-1:0] vertex_by;
    logic signed [COORD_W-1:0] vertex_cx;
    logic signed [COORD_W-1:0] vertex_cy;
    logic signed [BARY_W-1:0]  bary_a;
    logic signed [BARY_W-1:0]  bary_b;
    logic signed [BARY_W-1:0]  bary_c;
  } item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] shape_value;
    logic signed [OUT_W-1:0] slope_x;
    logic signed [OUT_W-1:0] slope_y;
    logic                    degenerate;
  } result_t;

  // classified work word: slope numerators are (a1*b1 + a2*b2) << (edge ? 2 : 0)
  typedef struct packed {
    logic                     shape_ok;
    logic                     is_edge;
    logic signed [OPA_W-1:0]  op_a1;
    logic signed [OPA_W-1:0]  op_a2;
    logic signed [DIFF_W-1:0] op_bx1;
    logic signed [DIFF_W-1:0] op_bx2;
    logic signed [DIFF_W-1:0] op_by1;
    logic signed [DIFF_W-1:0] op_by2;
    logic signed [BARY_W-1:0] val_k;
    logic signed [VALM_W-1:0] val_m;
    logic signed [DIFF_W-1:0] dx21;
    logic signed [DIFF_W-1:0] dy31;
    logic signed [DIFF_W-1:0] dy12;
    logic signed [DIFF_W-1:0] dx13;
  } work_t;

endpackage

/* src/qtse_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtse_front: accept and classify
// Takes an item, forms coordinate differences and picks the multiplier
// operands for the requested shape function.
// ----------------------------------------------------------------------------
module qtse_front #(
  parameter int BARY_FRAC_BITS = qtse_pkg::BARY_FRAC_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  qtse_pkg::item_t     item_i,
  output logic                push_o,
  output qtse_pkg::work_t     work_o
);

  localparam int DW = qtse_pkg::DIFF_W;
  localparam int AW = qtse_pkg::OPA_W;
  localparam int MW = qtse_pkg::VALM_W;
  localparam logic signed [AW-1:0] ONE_A = AW'(1) << BARY_FRAC_BITS;
  localparam logic signed [MW-1:0] ONE_M = MW'(1) << BARY_FRAC_BITS;

  logic signed [DW-1:0] dy23, dy31, dy12, dx32, dx13, dx21;
  logic signed [AW-1:0] f0, f1, f2;
  logic signed [MW-1:0] m0, m1, m2;
  qtse_pkg::work_t      work_d, work_q;
  logic                 push_q;

  assign dy23 = DW'(item_i.vertex_by) - DW'(item_i.vertex_cy);
  assign dy31 = DW'(item_i.vertex_cy) - DW'(item_i.vertex_ay);
  assign dy12 = DW'(item_i.vertex_ay) - DW'(item_i.vertex_by);
  assign dx32 = DW'(item_i.vertex_cx) - DW'(item_i.vertex_bx);
  assign dx13 = DW'(item_i.vertex_ax) - DW'(item_i.vertex_cx);
  assign dx21 = DW'(item_i.vertex_bx) - DW'(item_i.vertex_ax);

  assign f0 = (AW'(item_i.bary_a) <<< 2) - ONE_A;
  assign f1 = (AW'(item_i.bary_b) <<< 2) - ONE_A;
  assign f2 = (AW'(item_i.bary_c) <<< 2) - ONE_A;
  assign m0 = (MW'(item_i.bary_a) <<< 1) - ONE_M;
  assign m1 = (MW'(item_i.bary_b) <<< 1) - ONE_M;
  assign m2 = (MW'(item_i.bary_c) <<< 1) - ONE_M;

  always_comb begin
    work_d          = '0;
    work_d.shape_ok = 1'b1;
    work_d.dx21     = dx21;
    work_d.dy31     = dy31;
    work_d.dy12     = dy12;
    work_d.dx13     = dx13;
    unique case (item_i.shape_index)
      qtse_pkg::SHAPE_CORNER_A: begin
        work_d.op_a1  = f0;
        work_d.op_bx1 = dy23;
        work_d.op_by1 = dx32;
        work_d.val_k  = item_i.bary_a;
        work_d.val_m  = m0;
      end
      qtse_pkg::SHAPE_CORNER_B: begin
        work_d.op_a1  = f1;
        work_d.op_bx1 = dy31;
        work_d.op_by1 = dx13;
        work_d.val_k  = item_i.bary_b;
        work_d.val_m  = m1;
      end
      qtse_pkg::SHAPE_CORNER_C: begin
        work_d.op_a1  = f2;
        work_d.op_bx1 = dy12;
        work_d.op_by1 = dx21;
        work_d.val_k  = item_i.bary_c;
        work_d.val_m  = m2;
      end
      qtse_pkg::SHAPE_EDGE_AB: begin
        work_d.is_edge = 1'b1;
        work_d.op_a1   = AW'(item_i.bary_b);
        work_d.op_a2   = AW'(item_i.bary_a);
        work_d.op_bx1  = dy23;
        work_d.op_bx2  = dy31;
        work_d.op_by1  = dx32;
        work_d.op_by2  = dx13;
        work_d.val_k   = item_i.bary_a;
        work_d.val_m   = MW'(item_i.bary_b);
      end
      qtse_pkg::SHAPE_EDGE_BC: begin
        work_d.is_edge = 1'b1;
        work_d.op_a1   = AW'(item_i.bary_c);
        work_d.op_a2   = AW'(item_i.bary_b);
        work_d.op_bx1  = dy31;
        work_d.op_bx2  = dy12;
        work_d.op_by1  = dx13;
        work_d.op_by2  = dx21;
        work_d.val_k   = item_i.bary_b;
        work_d.val_m   = MW'(item_i.bary_c);
      end
      qtse_pkg::SHAPE_EDGE_CA: begin
        work_d.is_edge = 1'b1;
        work_d.op_a1   = AW'(item_i.bary_a);
        work_d.op_a2   = AW'(item_i.bary_c);
        work_d.op_bx1  = dy12;
        work_d.op_bx2  = dy23;
        work_d.op_by1  = dx21;
        work_d.op_by2  = dx32;
        work_d.val_k   = item_i.bary_c;
        work_d.val_m   = MW'(item_i.bary_a);
      end
      default: begin
        work_d.shape_ok = 1'b0;   // unused codes give zero results
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push_q <= 1'b0;
    end else begin
      push_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      work_q <= work_d;
    end
  end

  assign push_o = push_q;
  assign work_o = work_q;

endmodule

/* src/qtse_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtse_fifo: work queue
// Short queue of classified work words between front and back.
// ----------------------------------------------------------------------------
module qtse_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  qtse_pkg::work_t data_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            avail_o,
  output qtse_pkg::work_t data_o
);

  localparam int DEPTH = qtse_pkg::FIFO_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  qtse_pkg::work_t  entries_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push_ok, pop_ok;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign avail_o = (count_q != '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && avail_o;
  assign data_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_ok, pop_ok})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* src/qtse_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtse_div: pipelined restoring divider
// One quotient bit per stage; flags quotients that do not fit QUOT_W bits.
// ----------------------------------------------------------------------------
module qtse_div #(
  parameter int NUM_W  = 84,
  parameter int DEN_W  = 68,
  parameter int QUOT_W = 48
) (
  input  logic              clk_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  output logic [QUOT_W-1:0] quot_o,
  output logic              ovf_o
);

  logic [NUM_W-1:0]  rem_q  [QUOT_W];
  logic [DEN_W-1:0]  den_q  [QUOT_W];
  logic [QUOT_W-1:0] quot_q [QUOT_W];
  logic              ovf_q  [QUOT_W];

  logic [NUM_W-1:0]  rem_in  [QUOT_W];
  logic [DEN_W-1:0]  den_in  [QUOT_W];
  logic [QUOT_W-1:0] quot_in [QUOT_W];
  logic              ovf_in  [QUOT_W];
  logic              take    [QUOT_W];

  always_comb begin
    logic [NUM_W-1:0] top;
    rem_in[0]  = num_i;
    den_in[0]  = den_i;
    quot_in[0] = '0;
    ovf_in[0]  = (num_i >> QUOT_W) >= NUM_W'(den_i);
    for (int s = 1; s < QUOT_W; s++) begin
      rem_in[s]  = rem_q[s-1];
      den_in[s]  = den_q[s-1];
      quot_in[s] = quot_q[s-1];
      ovf_in[s]  = ovf_q[s-1];
    end
    for (int s = 0; s < QUOT_W; s++) begin
      // remainder stays below den << (bit+1), so the top slice is narrow
      top     = rem_in[s] >> (QUOT_W - 1 - s);
      take[s] = top[DEN_W:0] >= {1'b0, den_in[s]};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < QUOT_W; s++) begin
      rem_q[s]  <= take[s] ? rem_in[s] - (NUM_W'(den_in[s]) << (QUOT_W - 1 - s))
                           : rem_in[s];
      den_q[s]  <= den_in[s];
      quot_q[s] <= quot_in[s] | (QUOT_W'(take[s]) << (QUOT_W - 1 - s));
      ovf_q[s]  <= ovf_in[s];
    end
  end

  assign quot_o = quot_q[QUOT_W-1];
  assign ovf_o  = ovf_q[QUOT_W-1];

endmodule

/* src/qtse_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtse_back: evaluation datapath
// Multiplies, sums, rounds and divides by twice the area; saturates results.
// ----------------------------------------------------------------------------
module qtse_back #(
  parameter int BARY_FRAC_BITS = qtse_pkg::BARY_FRAC_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  qtse_pkg::work_t   work_i,
  output logic              valid_o,
  output qtse_pkg::result_t result_o
);

  localparam int OUT_W  = qtse_pkg::OUT_W;
  localparam int QUOT_W = qtse_pkg::QUOT_W;
  localparam int PROD_W = qtse_pkg::PROD_W;
  localparam int VAL_W  = qtse_pkg::VAL_W;
  localparam int JP_W   = qtse_pkg::JP_W;
  localparam int J2_W   = qtse_pkg::J2_W;
  localparam int SH     = qtse_pkg::SLOPE_FRAC_REF - BARY_FRAC_BITS;
  localparam int V_SH   = 2 * BARY_FRAC_BITS - qtse_pkg::VALUE_FRAC;
  localparam int NUM_W  = PROD_W + 3;
  localparam int NUMS_W = NUM_W + SH;
  localparam int NP_W   = ((NUMS_W + 1 > J2_W) ? NUMS_W + 1 : J2_W) + 2;
  localparam int DP_W   = J2_W + 1;
  localparam logic [VAL_W:0] V_HALF = ((VAL_W + 1)'(1) << V_SH) >> 1;

  function automatic logic [OUT_W-1:0] sat_out(input logic neg,
                                               input logic [QUOT_W-1:0] mag,
                                               input logic ovf);
    logic [QUOT_W-1:0] lim, m;
    lim = (QUOT_W'(1) << (OUT_W - 1)) - QUOT_W'(!neg);
    m   = (ovf || mag > lim) ? lim : mag;
    return neg ? OUT_W'(-m) : OUT_W'(m);
  endfunction

  // stage 1: products
  logic                     s1_vld_q, s1_ok_q, s1_edge_q;
  logic signed [PROD_W-1:0] px1_d, px2_d, py1_d, py2_d, px1_q, px2_q, py1_q, py2_q;
  logic signed [VAL_W-1:0]  pv_d, pv_q;
  logic signed [JP_W-1:0]   pj1_d, pj2_d, pj1_q, pj2_q;

  always_comb begin
    px1_d = work_i.op_a1 * work_i.op_bx1;
    px2_d = work_i.op_a2 * work_i.op_bx2;
    py1_d = work_i.op_a1 * work_i.op_by1;
    py2_d = work_i.op_a2 * work_i.op_by2;
    pv_d  = work_i.val_k * work_i.val_m;
    pj1_d = work_i.dx21 * work_i.dy31;
    pj2_d = work_i.dy12 * work_i.dx13;
  end

  always_ff @(posedge clk_i) begin
    px1_q     <= px1_d;
    px2_q     <= px2_d;
    py1_q     <= py1_d;
    py2_q     <= py2_d;
    pv_q      <= pv_d;
    pj1_q     <= pj1_d;
    pj2_q     <= pj2_d;
    s1_ok_q   <= work_i.shape_ok;
    s1_edge_q <= work_i.is_edge;
  end

  // stage 2: numerators and twice the area
  logic                    s2_vld_q, s2_ok_q;
  logic signed [NUM_W-1:0] nx_d, ny_d, nx_q, ny_q;
  logic signed [VAL_W-1:0] nv_d, nv_q;
  logic signed [J2_W-1:0]  j2_d, j2_q;

  always_comb begin
    nx_d = NUM_W'(px1_q) + NUM_W'(px2_q);
    ny_d = NUM_W'(py1_q) + NUM_W'(py2_q);
    nv_d = pv_q;
    if (s1_edge_q) begin
      nx_d = nx_d <<< 2;
      ny_d = ny_d <<< 2;
      nv_d = nv_d <<< 2;
    end
    j2_d = J2_W'(pj1_q) - J2_W'(pj2_q);
  end

  always_ff @(posedge clk_i) begin
    nx_q    <= nx_d;
    ny_q    <= ny_d;
    nv_q    <= nv_d;
    j2_q    <= j2_d;
    s2_ok_q <= s1_ok_q;
  end

  // stage 3: magnitudes, rounded divider operands, shape value
  logic                s3_vld_q;
  logic [NUM_W-1:0]    magx, magy;
  logic [J2_W-1:0]     magd;
  logic [VAL_W-1:0]    magv;
  logic [VAL_W:0]      vround;
  logic [NP_W-1:0]     npx_d, npy_d, npx_q, npy_q;
  logic [DP_W-1:0]     dp_d, dp_q;
  logic [OUT_W-1:0]    value_d;
  logic                s3_negx_q, s3_negy_q, s3_degen_q, s3_ok_q;
  logic [OUT_W-1:0]    s3_value_q;

  always_comb begin
    magx   = nx_q[NUM_W-1] ? NUM_W'(-nx_q) : NUM_W'(nx_q);
    magy   = ny_q[NUM_W-1] ? NUM_W'(-ny_q) : NUM_W'(ny_q);
    magd   = j2_q[J2_W-1] ? J2_W'(-j2_q) : J2_W'(j2_q);
    magv   = nv_q[VAL_W-1] ? VAL_W'(-nv_q) : VAL_W'(nv_q);
    // round half away from zero: floor((2|n| + |d|) / (2|d|))
    npx_d  = (NP_W'(magx) << (SH + 1)) + NP_W'(magd);
    npy_d  = (NP_W'(magy) << (SH + 1)) + NP_W'(magd);
    dp_d   = DP_W'(magd) << 1;
    vround = ({1'b0, magv} + V_HALF) >> V_SH;
    value_d = sat_out(nv_q[VAL_W-1], vround[QUOT_W-1:0], |vround[VAL_W:QUOT_W]);
  end

  always_ff @(posedge clk_i) begin
    npx_q      <= npx_d;
    npy_q      <= npy_d;
    dp_q       <= dp_d;
    s3_negx_q  <= nx_q[NUM_W-1] ^ j2_q[J2_W-1];
    s3_negy_q  <= ny_q[NUM_W-1] ^ j2_q[J2_W-1];
    s3_degen_q <= (j2_q == '0);
    s3_ok_q    <= s2_ok_q;
    s3_value_q <= s2_ok_q ? value_d : '0;
  end

  // divider lanes
  logic [QUOT_W-1:0] qx, qy;
  logic              ovfx, ovfy;

  qtse_div #(.NUM_W(NP_W), .DEN_W(DP_W), .QUOT_W(QUOT_W)) u_div_x (
    .clk_i  (clk_i),
    .num_i  (npx_q),
    .den_i  (dp_q),
    .quot_o (qx),
    .ovf_o  (ovfx)
  );

  qtse_div #(.NUM_W(NP_W), .DEN_W(DP_W), .QUOT_W(QUOT_W)) u_div_y (
    .clk_i  (clk_i),
    .num_i  (npy_q),
    .den_i  (dp_q),
    .quot_o (qy),
    .ovf_o  (ovfy)
  );

  // sideband delay line matching the divider depth
  logic             sb_vld_q   [QUOT_W];
  logic             sb_negx_q  [QUOT_W];
  logic             sb_negy_q  [QUOT_W];
  logic             sb_degen_q [QUOT_W];
  logic             sb_ok_q    [QUOT_W];
  logic [OUT_W-1:0] sb_value_q [QUOT_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      for (int s = 0; s < QUOT_W; s++) begin
        sb_vld_q[s] <= 1'b0;
      end
      valid_o <= 1'b0;
    end else begin
      s1_vld_q    <= in_valid_i;
      s2_vld_q    <= s1_vld_q;
      s3_vld_q    <= s2_vld_q;
      sb_vld_q[0] <= s3_vld_q;
      for (int s = 1; s < QUOT_W; s++) begin
        sb_vld_q[s] <= sb_vld_q[s-1];
      end
      valid_o <= sb_vld_q[QUOT_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    sb_negx_q[0]  <= s3_negx_q;
    sb_negy_q[0]  <= s3_negy_q;
    sb_degen_q[0] <= s3_degen_q;
    sb_ok_q[0]    <= s3_ok_q;
    sb_value_q[0] <= s3_value_q;
    for (int s = 1; s < QUOT_W; s++) begin
      sb_negx_q[s]  <= sb_negx_q[s-1];
      sb_negy_q[s]  <= sb_negy_q[s-1];
      sb_degen_q[s] <= sb_degen_q[s-1];
      sb_ok_q[s]    <= sb_ok_q[s-1];
      sb_value_q[s] <= sb_value_q[s-1];
    end
  end

  // output register
  logic slope_on;
  assign slope_on = sb_ok_q[QUOT_W-1] && !sb_degen_q[QUOT_W-1];

  always_ff @(posedge clk_i) begin
    result_o.shape_value <= sb_value_q[QUOT_W-1];
    result_o.slope_x     <= slope_on ? sat_out(sb_negx_q[QUOT_W-1], qx, ovfx) : '0;
    result_o.slope_y     <= slope_on ? sat_out(sb_negy_q[QUOT_W-1], qy, ovfy) : '0;
    result_o.degenerate  <= sb_degen_q[QUOT_W-1];
  end

endmodule

/* src/quadratic_triangle_shape_eval.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_triangle_shape_eval: six-node triangle shape function evaluator
// Returns N, dN/dx and dN/dy of one quadratic shape function at a point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive item_i and raise start; the word is taken at a
//   rising edge where start is high and busy is low. busy only rises if the
//   internal work queue fills, which the free-running back end prevents, so
//   a new word can be taken every cycle.
//   Result channel: valid_o is high for one cycle with the result word on
//   result_o. There is no back pressure; results must be captured in that
//   cycle.
//   A word passes the classify stage, the work queue, multiply, sum and
//   operand prep, then the 48-stage divider pipeline (one quotient bit per
//   stage) and the output register. Throughput is one word per cycle.
//   Twice the signed area is the divisor; zero area forces the slopes to
//   zero and sets degenerate. Shape codes 6 and 7 give zero results.
//   Reset clears the handshake, queue and pipeline valid bits; words in
//   flight are dropped and no result strobes until new words arrive.
// ----------------------------------------------------------------------------
module quadratic_triangle_shape_eval #(
  parameter int BARY_FRAC_BITS = qtse_pkg::BARY_FRAC_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  qtse_pkg::item_t   item_i,
  output logic              valid_o,
  output qtse_pkg::result_t result_o
);

  localparam int LATENCY = qtse_pkg::QUOT_W + 6;

  logic            accept;
  logic            push;
  qtse_pkg::work_t front_work;
  logic            avail;
  qtse_pkg::work_t queue_work;

  assign accept = start && !busy;

  qtse_front #(.BARY_FRAC_BITS(BARY_FRAC_BITS)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item_i),
    .push_o   (push),
    .work_o   (front_work)
  );

  qtse_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_work),
    .pop_i   (avail),          // back end never stalls
    .full_o  (busy),
    .avail_o (avail),
    .data_o  (queue_work)
  );

  qtse_back #(.BARY_FRAC_BITS(BARY_FRAC_BITS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (avail),
    .work_i     (queue_work),
    .valid_o    (valid_o),
    .result_o   (result_o)
  );

`ifndef SYNTHESIS
  // every accepted word produces a result strobe
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY valid_o)
    else $error("result strobe missing after accepted word");

  // zero area never reports a slope
  a_degen_slopes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.degenerate) |-> (result_o.slope_x == '0 &&
                                          result_o.slope_y == '0))
    else $error("nonzero slope on degenerate triangle");

  // unused shape codes give zero results
  a_bad_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item_i.shape_index > qtse_pkg::SHAPE_EDGE_CA) |-> ##LATENCY
      (result_o.shape_value == '0 && result_o.slope_x == '0 &&
       result_o.slope_y == '0))
    else $error("unused shape code gave a nonzero result");

  // the queue drains every cycle, so the input never backs up
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("work queue filled");
`endif

endmodule
